// File: src/ttcw_pkg.sv
`default_nettype none

package ttcw_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;
    localparam int DEF_TAB_STOP      = 8;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CIDX_W  = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int POS_FULL_W = 13;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [POS_FULL_W-1:0] HW_PITCH = 13'd80;

    localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BACK  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [15:0]        CELL_BLANK       = 16'h0720;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ADV,
        ST_SCROLL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                updated;
        logic [POS_W-1:0]    pos;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [COLOR_W-1:0]  color;
        logic [CHAR_W-1:0]   glyph;
    } t_result;

endpackage

`default_nettype wire

// File: src/ttcw_screen_ram.sv
`default_nettype none

module ttcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/ttcw_ctrl.sv
`default_nettype none

module ttcw_ctrl import ttcw_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int TAB_STOP      = DEF_TAB_STOP,
    parameter int AW            = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_action,
    input  wire logic [CHAR_W-1:0]  i_char,
    input  wire logic [CIDX_W-1:0]  i_cidx,
    input  wire logic [COLOR_W-1:0] i_text_color,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output t_result                 o_res,
    output logic                    o_we,
    output logic      [AW-1:0]      o_waddr,
    output logic      [15:0]        o_wdata,
    output logic      [AW-1:0]      o_raddr,
    input  wire logic [15:0]        i_rdata
);

    localparam int CC = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int CW = $clog2(SCREEN_WIDTH);
    localparam int PW = $clog2(TAB_STOP);
    localparam int NW = $clog2(TAB_STOP + 1);
    localparam int XW = (AW > CIDX_W) ? AW : CIDX_W;

    t_state              r_state, n_state;
    logic [AW:0]         r_addr, n_addr;
    logic                r_cp_vld, n_cp_vld;
    logic [AW-1:0]       r_cp_dst, n_cp_dst;
    logic [RW-1:0]       r_row, n_row;
    logic [CW-1:0]       r_col, n_col;
    logic [PW-1:0]       r_phase, n_phase;
    logic [NW-1:0]       r_cnt, n_cnt;
    logic [CHAR_W-1:0]   r_glyph, n_glyph;
    logic                r_lf, n_lf;
    logic                r_rd_ok, n_rd_ok;
    logic [CHAR_W-1:0]   r_res_glyph, n_res_glyph;
    logic [COLOR_W-1:0]  r_res_color, n_res_color;
    logic                r_upd, n_upd;

    logic [AW-1:0]         cur_addr, bs_addr;
    logic [CW-1:0]         bs_col;
    logic [CW:0]           col_inc;
    logic                  wrap, last_row;
    logic [PW-1:0]         phase_inc, phase_dec;
    logic [XW-1:0]         cidx_x;
    logic                  rd_ok;
    logic [NW-1:0]         tab_n;
    logic [POS_FULL_W-1:0] pos_full;

    assign cur_addr  = AW'(AW'(r_row) * AW'(SCREEN_WIDTH)) + AW'(r_col);
    assign bs_col    = (r_col != '0) ? r_col - 1'b1 : r_col;
    assign bs_addr   = AW'(AW'(r_row) * AW'(SCREEN_WIDTH)) + AW'(bs_col);
    assign col_inc   = {1'b0, r_col} + 1'b1;
    assign wrap      = (col_inc >= (CW+1)'(SCREEN_WIDTH)) || r_lf;
    assign last_row  = (r_row == RW'(SCREEN_HEIGHT - 1));
    assign phase_inc = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + 1'b1;
    assign phase_dec = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - 1'b1;
    assign cidx_x    = XW'(i_cidx);
    assign rd_ok     = ({1'b0, cidx_x} < (XW+1)'(CC));
    assign tab_n     = NW'(TAB_STOP) - NW'(r_phase);
    assign pos_full  = POS_FULL_W'(r_row) * HW_PITCH + POS_FULL_W'(r_col);

    assign o_res.glyph   = r_res_glyph;
    assign o_res.color   = r_res_color;
    assign o_res.row     = ROW_W'(r_row);
    assign o_res.col     = COL_W'(r_col);
    assign o_res.pos     = pos_full[POS_W-1:0];
    assign o_res.updated = r_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_addr   <= '0;
            r_cp_vld <= 1'b0;
            r_row    <= '0;
            r_col    <= '0;
            r_phase  <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_cp_vld <= n_cp_vld;
            r_row    <= n_row;
            r_col    <= n_col;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_dst    <= n_cp_dst;
        r_glyph     <= n_glyph;
        r_lf        <= n_lf;
        r_rd_ok     <= n_rd_ok;
        r_res_glyph <= n_res_glyph;
        r_res_color <= n_res_color;
        r_upd       <= n_upd;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cp_vld    = 1'b0;
        n_cp_dst    = r_cp_dst;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_glyph     = r_glyph;
        n_lf        = r_lf;
        n_rd_ok     = r_rd_ok;
        n_res_glyph = r_res_glyph;
        n_res_color = r_res_color;
        n_upd       = r_upd;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = cur_addr;
        o_wdata     = {i_text_color, r_glyph};
        o_raddr     = cidx_x[AW-1:0];

        case (r_state)
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_addr[AW-1:0];
                o_wdata = CELL_BLANK;
                n_addr  = r_addr + 1'b1;
                if (r_addr == (AW+1)'(CC - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_upd       = 1'b0;
                    n_res_glyph = '0;
                    n_res_color = '0;
                    if (i_action) begin
                        n_rd_ok = rd_ok;
                        n_state = ST_READ;
                    end else begin
                        case (i_char)
                            CH_CR: begin
                                n_col   = '0;
                                n_phase = '0;
                                n_state = ST_DONE;
                            end
                            CH_BELL: begin
                                n_state = ST_DONE;
                            end
                            CH_BACK: begin
                                n_col   = bs_col;
                                n_phase = (r_col != '0) ? phase_dec : r_phase;
                                o_we    = 1'b1;
                                o_waddr = bs_addr;
                                o_wdata = {i_text_color, CH_SPACE};
                                n_state = ST_DONE;
                            end
                            CH_TAB: begin
                                n_glyph = CH_SPACE;
                                n_lf    = 1'b0;
                                n_cnt   = tab_n;
                                n_upd   = 1'b1;
                                n_state = ST_ADV;
                            end
                            CH_LF: begin
                                n_glyph = i_char;
                                n_lf    = 1'b1;
                                n_cnt   = NW'(1);
                                n_upd   = 1'b1;
                                n_state = ST_ADV;
                            end
                            default: begin
                                n_glyph = i_char;
                                n_lf    = 1'b0;
                                n_cnt   = NW'(1);
                                n_upd   = 1'b1;
                                n_state = ST_ADV;
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                n_res_glyph = r_rd_ok ? i_rdata[7:0] : '0;
                n_res_color = r_rd_ok ? i_rdata[15:8] : '0;
                n_state     = ST_DONE;
            end
            ST_ADV: begin
                o_we  = !r_lf;
                n_cnt = r_cnt - 1'b1;
                if (wrap) begin
                    n_col   = '0;
                    n_phase = '0;
                    if (last_row) begin
                        n_addr  = (AW+1)'(SCREEN_WIDTH);
                        n_state = ST_SCROLL;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = (n_cnt == '0) ? ST_DONE : ST_ADV;
                    end
                end else begin
                    n_col   = col_inc[CW-1:0];
                    n_phase = phase_inc;
                    n_state = (n_cnt == '0) ? ST_DONE : ST_ADV;
                end
            end
            ST_SCROLL: begin
                // read row below, write one row up on the next cycle
                o_raddr = r_addr[AW-1:0];
                if (r_addr < (AW+1)'(CC)) begin
                    n_cp_vld = 1'b1;
                    n_cp_dst = r_addr[AW-1:0] - AW'(SCREEN_WIDTH);
                    n_addr   = r_addr + 1'b1;
                end
                o_we    = r_cp_vld;
                o_waddr = r_cp_dst;
                o_wdata = i_rdata;
                if (r_addr == (AW+1)'(CC) && r_cp_vld) begin
                    n_state = (r_cnt == '0) ? ST_DONE : ST_ADV;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_read_goes_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_action) |=> (r_state == ST_READ))
        else $error("read transfer did not start a cell read");

    a_copy_only_in_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> (r_state == ST_SCROLL))
        else $error("scroll copy write outside scroll");

    a_phase_tracks_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == '0) |-> (r_phase == '0))
        else $error("tab phase out of step with column");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= RW'(SCREEN_HEIGHT - 1)) && ({1'b0, r_col} < (CW+1)'(SCREEN_WIDTH)))
        else $error("cursor outside the screen");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_res_ready) |=> (r_state == ST_DONE))
        else $error("result dropped before transfer");

endmodule

`default_nettype wire

// File: src/text_terminal_char_writer.sv
// Flow: CR, bell and backspace go from IDLE straight to DONE; a read passes through READ,
//   a character through ADV, and a tab through ADV once per column; o_m_tvalid is registered.
// Throughput: one item at a time; a scroll runs through SCROLL before the item completes,
//   one cell copied per cycle through the single read/write screen RAM.
// Reset: i_rst_n synchronous, active low; afterwards a clearing pass fills all
//   SCREEN_WIDTH*SCREEN_HEIGHT cells (2000 by default) with blanks, o_s_tready low.
`default_nettype none

module text_terminal_char_writer import ttcw_pkg::*; #(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
    parameter int TAB_STOP      = DEF_TAB_STOP
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [S_TDATA_W-1:0]   i_s_tdata,   // char_code, cell_index, zero pad
    input  wire logic [0:0]             i_s_tuser,   // action
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic      [M_TDATA_W-1:0]   o_m_tdata,   // read_glyph, read_color, cursor_row,
                                                     // cursor_col, cursor_position,
                                                     // cursor_updated
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [COLOR_W-1:0]     i_cfg_data
);

    localparam int CC = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW = $clog2(CC);

    logic [COLOR_W-1:0]   r_text_color;
    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    logic          res_valid, res_ready;
    t_result       res;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;

    assign o_cfg_ready = 1'b1;
    assign res_ready   = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RESET;
        end else if (i_cfg_valid) begin
            r_text_color <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_m_tdata <= res;
        end
    end

    ttcw_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TAB_STOP      (TAB_STOP),
        .AW            (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_action     (i_s_tuser[0]),
        .i_char       (i_s_tdata[CHAR_W-1:0]),
        .i_cidx       (i_s_tdata[CHAR_W+CIDX_W-1:CHAR_W]),
        .i_text_color (r_text_color),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    ttcw_screen_ram #(
        .DEPTH (CC),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire
